// ===== rtl/aeo_pkg.sv =====
// ----------------------------------------------------------------------------
// aeo_pkg: shared types, constants and tables
// Constants, tables and helper functions of the enveloped oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package aeo_pkg;

  localparam int SAMPLE_RATE     = 48000;
  localparam int RELEASE_CV_GAIN = 0;
  localparam int SINE_DEPTH      = 256;
  localparam int SINE_AW         = $clog2(SINE_DEPTH);

  // per-tick ramp step for a one millisecond stage, Q1.31
  localparam logic [31:0] STAGE_BASE = 32'((64'd1000 << 31) / SAMPLE_RATE);
  // base oscillator step per tick, scaled so a later shift sets the octave
  localparam logic [31:0] FREQ_STEP  = 32'(64'd1123673395796 / SAMPLE_RATE);
  localparam logic [31:0] LOG2_10000 = 32'd870824;
  localparam logic [31:0] RECIP_5000 = 32'((64'd1 << 32) / 5000);
  localparam logic [31:0] RECIP_1000 = 32'((64'd1 << 40) / 1000);
  localparam logic [31:0] CV_DIV     = 32'd5000;
  localparam logic [31:0] PITCH_DIV  = 32'd1000;
  localparam logic [31:0] FULL_MV    = 32'd5000;
  localparam logic [15:0] PITCH_BIAS = 16'd21000;
  localparam logic [5:0]  OCT_BIAS   = 6'd36;
  localparam logic [16:0] RELEASE_AMT = 17'(RELEASE_CV_GAIN);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    STG_OFF     = 3'd0,
    STG_ATTACK  = 3'd1,
    STG_DECAY   = 3'd2,
    STG_SUSTAIN = 3'd3,
    STG_RELEASE = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    CFG_ATTACK_KNOB  = 3'd0,
    CFG_DECAY_KNOB   = 3'd1,
    CFG_SUSTAIN_KNOB = 3'd2,
    CFG_RELEASE_KNOB = 3'd3,
    CFG_PITCH_OFFSET = 3'd4,
    CFG_ATTACK_AMT   = 3'd5,
    CFG_DECAY_AMT    = 3'd6,
    CFG_SUSTAIN_AMT  = 3'd7
  } cfg_index_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CV_MUL, S_CV_REC, S_CV_FIX, S_CV_END,
    S_INC_E, S_INC_P, S_INC_B, S_INC_END,
    S_PIT_REC, S_PIT_FIX, S_PIT_POW, S_PIT_MUL, S_PIT_END,
    S_W_MAG, S_W_SC, S_W_RND, S_DONE
  } state_t;

  // 2^(-k/16), Q16
  localparam logic [16:0] POW2NEG [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  typedef logic [15:0] sine_tab_t [SINE_DEPTH];

  // quarter sine by odd power series, evaluated at elaboration
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint unsigned x, x2, t, s, e, one;
    one = 64'd1 << 30;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x  = HALF_PI_Q30 * 64'(i) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t  = one;
      t  = one - ((x2 * t) >> 30) / 110;
      t  = one - ((x2 * t) >> 30) / 72;
      t  = one - ((x2 * t) >> 30) / 42;
      t  = one - ((x2 * t) >> 30) / 20;
      t  = one - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      e  = (s * 64'd65535 + (64'd1 << 29)) >> 30;
      tab[i] = (e > 64'd65535) ? 16'hFFFF : 16'(e);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // slope between two neighbouring points of the 2^-x table
  function automatic logic [15:0] p2n_diff(input logic [3:0] idx);
    return 16'(POW2NEG[idx] - POW2NEG[5'(idx) + 5'd1]);
  endfunction

  // table point minus rounded interpolation term
  function automatic logic [16:0] p2n_final(input logic [4:0] idx, input logic [23:0] dr);
    if (idx >= 5'd16) begin
      return 17'd32768;
    end
    return POW2NEG[idx] - 17'((25'(dr) + 25'd2048) >> 12);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aeo_if.sv =====
// ----------------------------------------------------------------------------
// aeo_if: request channels of the enveloped oscillator
// Sample tick, result and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface aeo_tick_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] gate_mv;
  logic signed [14:0] pitch_mv;
  logic signed [14:0] attack_cv_mv;
  logic signed [14:0] decay_cv_mv;
  logic signed [14:0] sustain_cv_mv;
  logic signed [14:0] release_cv_mv;
  modport source (output valid, gate_mv, pitch_mv, attack_cv_mv, decay_cv_mv,
                  sustain_cv_mv, release_cv_mv, input ready);
  modport sink (input valid, gate_mv, pitch_mv, attack_cv_mv, decay_cv_mv,
                sustain_cv_mv, release_cv_mv, output ready);
endinterface

interface aeo_result_if;
  logic               valid;
  logic               ready;
  logic signed [13:0] sine_mv;
  logic signed [13:0] triangle_mv;
  logic signed [13:0] saw_mv;
  logic signed [13:0] square_mv;
  logic [16:0]        envelope_level;
  logic [2:0]         env_stage;
  modport source (output valid, sine_mv, triangle_mv, saw_mv, square_mv,
                  envelope_level, env_stage, input ready);
  modport sink (input valid, sine_mv, triangle_mv, saw_mv, square_mv,
                envelope_level, env_stage, output ready);
endinterface

interface aeo_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/adsr_enveloped_oscillator.sv =====
// ----------------------------------------------------------------------------
// adsr_enveloped_oscillator: ADSR envelope driving a four-wave oscillator
// Sequenced datapath around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// One sample tick request is taken when the block is idle; its result request
// appears as the sequencer returns to idle, where the next tick can be taken.
// The one shared 32x32 multiplier works through the products of two control
// voltages, the ramp step, the pitch step and four scaled waves, one product
// per cycle. The result sits in an output register, so a tick can be worked
// on while the previous result still waits to be taken.
// Register writes are always taken and should only be made while idle.
`default_nettype none

module adsr_enveloped_oscillator (
  input  wire              clk,
  input  wire              rst,
  aeo_tick_if.sink         tick,
  aeo_result_if.source     result,
  aeo_cfg_if.sink          cfg
);

  // configuration registers
  logic [16:0]        attack_knob, decay_knob, sustain_knob, release_knob;
  logic signed [12:0] pitch_offset;
  logic [16:0]        attack_cv_amount, decay_cv_amount, sustain_cv_amount;

  // envelope and oscillator state
  aeo_pkg::stage_t    stage_reg, stage_acc;
  logic               gate_trigger_high, trig_acc;
  logic [31:0]        osc_phase;
  logic [31:0]        env_level;

  // latched tick
  logic signed [14:0] pitch_mv, attack_cv_mv, decay_cv_mv, sustain_cv_mv, release_cv_mv;

  // sequencer and datapath
  aeo_pkg::state_t    state, state_next;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic               cv_sel;
  logic               cv_neg;
  logic [31:0]        acc;
  logic [21:0]        quo;
  logic [16:0]        sus_val, ctl_val;
  logic [3:0]         n_shift;
  logic [4:0]         p_idx;
  logic [5:0]         p_hi;
  logic [1:0]         wave_sel;
  logic [13:0]        res [4];

  // output register
  logic               out_valid;
  logic signed [13:0] out_sine, out_tri, out_saw, out_sqr;
  logic [16:0]        out_level;
  logic [2:0]         out_stage;

  logic tick_acc, res_acc;

  assign tick.ready = (state == aeo_pkg::S_IDLE);
  assign cfg.ready  = 1'b1;
  assign tick_acc   = tick.valid && tick.ready;
  assign res_acc    = result.valid && result.ready;

  assign result.valid          = out_valid;
  assign result.sine_mv        = out_sine;
  assign result.triangle_mv    = out_tri;
  assign result.saw_mv         = out_saw;
  assign result.square_mv      = out_sqr;
  assign result.envelope_level = out_level;
  assign result.env_stage      = out_stage;

  // gate schmitt trigger and stage change on the incoming tick
  always_comb begin
    trig_acc  = gate_trigger_high;
    stage_acc = stage_reg;
    if (gate_trigger_high) begin
      if (tick.gate_mv <= 15'sd0) trig_acc = 1'b0;
      if (tick.gate_mv < 15'sd1000 && stage_reg >= aeo_pkg::STG_ATTACK &&
          stage_reg <= aeo_pkg::STG_SUSTAIN) begin
        stage_acc = aeo_pkg::STG_RELEASE;
      end
    end else if (tick.gate_mv >= 15'sd1000) begin
      trig_acc  = 1'b1;
      stage_acc = aeo_pkg::STG_ATTACK;
    end else if (stage_reg >= aeo_pkg::STG_ATTACK && stage_reg <= aeo_pkg::STG_SUSTAIN) begin
      stage_acc = aeo_pkg::STG_RELEASE;
    end
  end

  // control voltage selection: sustain first, then the running stage's time
  logic [16:0]        knob_s, amt_s;
  logic signed [14:0] cv_s;
  logic [16:0]        amt_mag;
  logic [14:0]        cv_mag;
  always_comb begin
    knob_s = attack_knob;
    amt_s  = attack_cv_amount;
    cv_s   = attack_cv_mv;
    if (!cv_sel) begin
      knob_s = sustain_knob;
      amt_s  = sustain_cv_amount;
      cv_s   = sustain_cv_mv;
    end else begin
      unique case (stage_reg)
        aeo_pkg::STG_DECAY: begin
          knob_s = decay_knob;
          amt_s  = decay_cv_amount;
          cv_s   = decay_cv_mv;
        end
        aeo_pkg::STG_RELEASE: begin
          knob_s = release_knob;
          amt_s  = aeo_pkg::RELEASE_AMT;
          cv_s   = release_cv_mv;
        end
        default: ;
      endcase
    end
    amt_mag = amt_s[16] ? 17'(-amt_s) : amt_s;
    cv_mag  = cv_s[14] ? 15'(-cv_s) : 15'(cv_s);
  end

  // quotient correction and clamped control value
  logic [31:0]        cv_rem;
  logic [17:0]        cv_q;
  logic signed [19:0] cv_sum;
  logic [16:0]        cv_val;
  always_comb begin
    cv_rem = acc - prod[31:0];
    cv_q   = 18'(quo) + ((cv_rem >= aeo_pkg::CV_DIV) ? 18'd1 : 18'd0);
    cv_sum = cv_neg ? 20'(knob_s) - 20'(cv_q) : 20'(knob_s) + 20'(cv_q);
    if (cv_sum < 20'sd0)          cv_val = 17'd0;
    else if (cv_sum > 20'sd65536) cv_val = 17'd65536;
    else                          cv_val = cv_sum[16:0];
  end

  // envelope step
  logic [31:0] inc, sus32, lvl_new;
  logic [32:0] lvl_sum;
  aeo_pkg::stage_t stage_new;
  always_comb begin
    inc       = 32'(prod >> (16 + 32'(n_shift)));
    sus32     = {sus_val[16:0], 15'b0};
    lvl_sum   = {1'b0, env_level} + {1'b0, inc};
    lvl_new   = env_level;
    stage_new = stage_reg;
    unique case (stage_reg)
      aeo_pkg::STG_ATTACK: begin
        if (lvl_sum >= 33'h080000000) begin
          lvl_new   = 32'h80000000;
          stage_new = aeo_pkg::STG_DECAY;
        end else begin
          lvl_new = lvl_sum[31:0];
        end
      end
      aeo_pkg::STG_DECAY: begin
        if ({1'b0, env_level} <= {1'b0, sus32} + {1'b0, inc}) begin
          lvl_new   = sus32;
          stage_new = aeo_pkg::STG_SUSTAIN;
        end else begin
          lvl_new = env_level - inc;
        end
      end
      aeo_pkg::STG_SUSTAIN: lvl_new = sus32;
      aeo_pkg::STG_RELEASE: begin
        if (env_level <= inc) begin
          lvl_new   = 32'd0;
          stage_new = aeo_pkg::STG_OFF;
        end else begin
          lvl_new = env_level - inc;
        end
      end
      default: begin
        lvl_new   = 32'd0;
        stage_new = aeo_pkg::STG_OFF;
      end
    endcase
  end

  // pitch path
  logic [15:0] pitch_sum;
  logic [31:0] pit_rem;
  logic [21:0] p32;
  logic [16:0] pit_g;
  logic [47:0] step_val;
  logic [63:0] step_sh;
  always_comb begin
    pitch_sum = 16'(pitch_offset) + 16'(pitch_mv) + aeo_pkg::PITCH_BIAS;
    pit_rem   = acc - prod[31:0];
    p32       = quo + ((pit_rem >= aeo_pkg::PITCH_DIV) ? 22'd1 : 22'd0);
    pit_g     = 17'h10000 - 17'(p32[15:0]);
    step_val  = prod[47:0];
    if (p_hi >= aeo_pkg::OCT_BIAS) step_sh = 64'(step_val) << (p_hi - aeo_pkg::OCT_BIAS);
    else                           step_sh = 64'(step_val) >> (aeo_pkg::OCT_BIAS - p_hi);
  end

  // wave value of the current phase, as sign and magnitude
  logic [30:0]        sin_pos;
  logic [42:0]        sin_k_full;
  logic [12:0]        sin_k;
  logic [15:0]        sin_s;
  logic signed [33:0] wave;
  logic               w_neg;
  logic [31:0]        w_mag;
  logic [33:0]        w_abs;
  always_comb begin
    sin_pos    = osc_phase[30] ? 31'h40000000 - 31'(osc_phase[29:0]) : 31'(osc_phase[29:0]);
    sin_k_full = 43'(sin_pos) * 43'(aeo_pkg::SINE_DEPTH);
    sin_k      = sin_k_full[42:30];
    sin_s      = (sin_k >= 13'(aeo_pkg::SINE_DEPTH)) ? 16'hFFFF :
                 aeo_pkg::SINE_TAB[sin_k[aeo_pkg::SINE_AW-1:0]];
    case (wave_sel)
      2'd0: wave = osc_phase[31] ? -$signed(34'({sin_s, 15'b0}))
                                 : $signed(34'({sin_s, 15'b0}));
      2'd1: wave = osc_phase[31] ? 34'sh180000000 - $signed(34'({osc_phase, 1'b0}))
                                 : $signed(34'({osc_phase, 1'b0})) - 34'sh80000000;
      2'd2: wave = $signed(34'(osc_phase)) - 34'sh80000000;
      default: wave = osc_phase[31] ? -34'sh80000000 : 34'sh80000000;
    endcase
    w_neg = wave[33];
    w_abs = w_neg ? 34'(-wave) : 34'(wave);
    w_mag = w_abs[31:0];
  end

  logic [44:0] rnd_sum;
  logic [13:0] rnd_mv;
  assign rnd_sum = prod[44:0] + 45'h040000000;
  assign rnd_mv  = w_neg ? 14'(-rnd_sum[44:31]) : rnd_sum[44:31];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      aeo_pkg::S_IDLE:    if (tick_acc) state_next = aeo_pkg::S_CV_MUL;
      aeo_pkg::S_CV_MUL:  state_next = aeo_pkg::S_CV_REC;
      aeo_pkg::S_CV_REC:  state_next = aeo_pkg::S_CV_FIX;
      aeo_pkg::S_CV_FIX:  state_next = aeo_pkg::S_CV_END;
      aeo_pkg::S_CV_END:  state_next = cv_sel ? aeo_pkg::S_INC_E : aeo_pkg::S_CV_MUL;
      aeo_pkg::S_INC_E:   state_next = aeo_pkg::S_INC_P;
      aeo_pkg::S_INC_P:   state_next = aeo_pkg::S_INC_B;
      aeo_pkg::S_INC_B:   state_next = aeo_pkg::S_INC_END;
      aeo_pkg::S_INC_END: state_next = aeo_pkg::S_PIT_REC;
      aeo_pkg::S_PIT_REC: state_next = aeo_pkg::S_PIT_FIX;
      aeo_pkg::S_PIT_FIX: state_next = aeo_pkg::S_PIT_POW;
      aeo_pkg::S_PIT_POW: state_next = aeo_pkg::S_PIT_MUL;
      aeo_pkg::S_PIT_MUL: state_next = aeo_pkg::S_PIT_END;
      aeo_pkg::S_PIT_END: state_next = aeo_pkg::S_W_MAG;
      aeo_pkg::S_W_MAG:   state_next = aeo_pkg::S_W_SC;
      aeo_pkg::S_W_SC:    state_next = aeo_pkg::S_W_RND;
      aeo_pkg::S_W_RND:   state_next = (wave_sel == 2'd3) ? aeo_pkg::S_DONE : aeo_pkg::S_W_MAG;
      aeo_pkg::S_DONE:    if (!out_valid || result.ready) state_next = aeo_pkg::S_IDLE;
      default:            state_next = aeo_pkg::S_IDLE;
    endcase
  end

  // operands of the shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state)
      aeo_pkg::S_CV_MUL: begin
        mul_a = 32'(amt_mag);
        mul_b = 32'(cv_mag);
      end
      aeo_pkg::S_CV_REC: begin
        mul_a = prod[31:0];
        mul_b = aeo_pkg::RECIP_5000;
      end
      aeo_pkg::S_CV_FIX: begin
        mul_a = prod[63:32];
        mul_b = aeo_pkg::CV_DIV;
      end
      aeo_pkg::S_INC_E: begin
        mul_a = 32'(ctl_val);
        mul_b = aeo_pkg::LOG2_10000;
      end
      aeo_pkg::S_INC_P: begin
        mul_a = 32'(aeo_pkg::p2n_diff(prod[31:28]));
        mul_b = 32'(prod[27:16]);
      end
      aeo_pkg::S_INC_B: begin
        mul_a = aeo_pkg::STAGE_BASE;
        mul_b = 32'(aeo_pkg::p2n_final(p_idx, prod[23:0]));
      end
      aeo_pkg::S_PIT_REC: begin
        mul_a = {pitch_sum, 16'b0};
        mul_b = aeo_pkg::RECIP_1000;
      end
      aeo_pkg::S_PIT_FIX: begin
        mul_a = 32'(prod[63:40]);
        mul_b = aeo_pkg::PITCH_DIV;
      end
      aeo_pkg::S_PIT_POW: begin
        mul_a = 32'(aeo_pkg::p2n_diff(pit_g[15:12]));
        mul_b = 32'(pit_g[11:0]);
      end
      aeo_pkg::S_PIT_MUL: begin
        mul_a = aeo_pkg::FREQ_STEP;
        mul_b = 32'(aeo_pkg::p2n_final(p_idx, prod[23:0]));
      end
      aeo_pkg::S_W_MAG: begin
        mul_a = w_mag;
        mul_b = env_level;
      end
      aeo_pkg::S_W_SC: begin
        mul_a = prod[62:31];
        mul_b = aeo_pkg::FULL_MV;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= aeo_pkg::S_IDLE;
      out_valid         <= 1'b0;
      stage_reg         <= aeo_pkg::STG_OFF;
      gate_trigger_high <= 1'b0;
      env_level         <= 32'd0;
      osc_phase         <= 32'd0;
      attack_knob       <= 17'd6554;
      decay_knob        <= 17'd32768;
      sustain_knob      <= 17'd32768;
      release_knob      <= 17'd13107;
      pitch_offset      <= 13'sd0;
      attack_cv_amount  <= 17'd0;
      decay_cv_amount   <= 17'd0;
      sustain_cv_amount <= 17'd0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (aeo_pkg::cfg_index_t'(cfg.index))
          aeo_pkg::CFG_ATTACK_KNOB:  attack_knob       <= cfg.data;
          aeo_pkg::CFG_DECAY_KNOB:   decay_knob        <= cfg.data;
          aeo_pkg::CFG_SUSTAIN_KNOB: sustain_knob      <= cfg.data;
          aeo_pkg::CFG_RELEASE_KNOB: release_knob      <= cfg.data;
          aeo_pkg::CFG_PITCH_OFFSET: pitch_offset      <= cfg.data[12:0];
          aeo_pkg::CFG_ATTACK_AMT:   attack_cv_amount  <= cfg.data;
          aeo_pkg::CFG_DECAY_AMT:    decay_cv_amount   <= cfg.data;
          aeo_pkg::CFG_SUSTAIN_AMT:  sustain_cv_amount <= cfg.data;
          default: ;
        endcase
      end
      if (tick_acc) begin
        stage_reg         <= stage_acc;
        gate_trigger_high <= trig_acc;
      end
      if (state == aeo_pkg::S_INC_END) begin
        env_level <= lvl_new;
        stage_reg <= stage_new;
      end
      if (state == aeo_pkg::S_PIT_END) osc_phase <= osc_phase + step_sh[31:0];
      if (state == aeo_pkg::S_DONE && (!out_valid || result.ready)) out_valid <= 1'b1;
      else if (res_acc) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      pitch_mv      <= tick.pitch_mv;
      attack_cv_mv  <= tick.attack_cv_mv;
      decay_cv_mv   <= tick.decay_cv_mv;
      sustain_cv_mv <= tick.sustain_cv_mv;
      release_cv_mv <= tick.release_cv_mv;
      cv_sel        <= 1'b0;
      wave_sel      <= 2'd0;
    end
    unique case (state)
      aeo_pkg::S_CV_MUL: cv_neg <= amt_s[16] ^ cv_s[14];
      aeo_pkg::S_CV_REC: acc <= prod[31:0];
      aeo_pkg::S_CV_FIX: quo <= 22'(prod[63:32]);
      aeo_pkg::S_CV_END: begin
        if (cv_sel) ctl_val <= cv_val;
        else        sus_val <= cv_val;
        cv_sel <= 1'b1;
      end
      aeo_pkg::S_INC_P: begin
        n_shift <= prod[35:32];
        p_idx   <= {1'b0, prod[31:28]};
      end
      aeo_pkg::S_PIT_REC: acc <= {pitch_sum, 16'b0};
      aeo_pkg::S_PIT_FIX: quo <= prod[61:40];
      aeo_pkg::S_PIT_POW: begin
        p_idx <= pit_g[16:12];
        p_hi  <= p32[21:16];
      end
      aeo_pkg::S_W_RND: begin
        res[wave_sel] <= rnd_mv;
        wave_sel      <= wave_sel + 2'd1;
      end
      aeo_pkg::S_DONE: begin
        if (!out_valid || result.ready) begin
          out_sine  <= res[0];
          out_tri   <= res[1];
          out_saw   <= res[2];
          out_sqr   <= res[3];
          out_level <= env_level[31:15];
          out_stage <= stage_reg;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/aeo_checker.sv =====
// ----------------------------------------------------------------------------
// aeo_checker: port checks of the enveloped oscillator
// Watches the top level's channels and reports slips by $error.
// ----------------------------------------------------------------------------
`default_nettype none

module aeo_checker (
  input wire              clk,
  input wire              rst,
  input wire              tick_valid,
  input wire              tick_ready,
  input wire              res_valid,
  input wire              res_ready,
  input wire signed [13:0] sine_mv,
  input wire signed [13:0] square_mv,
  input wire [16:0]       envelope_level,
  input wire [2:0]        env_stage
);

  // a held result keeps its square wave and stage fields
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(square_mv) && $stable(env_stage))
    else $error("result changed while stalled");

  // one tick at a time: busy right after a tick is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick taken while busy");

  // an idle envelope is silent
  a_off_silent: assert property (@(posedge clk) disable iff (rst)
    res_valid && env_stage == 3'(aeo_pkg::STG_OFF) |->
      envelope_level == 17'd0 && sine_mv == 14'sd0 && square_mv == 14'sd0)
    else $error("off stage with non-zero output");

  // level never above full, stage within range
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> envelope_level <= 17'd65536 && env_stage <= 3'(aeo_pkg::STG_RELEASE))
    else $error("envelope out of range");

endmodule

bind adsr_enveloped_oscillator aeo_checker u_aeo_checker (
  .clk            (clk),
  .rst            (rst),
  .tick_valid     (tick.valid),
  .tick_ready     (tick.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .sine_mv        (result.sine_mv),
  .square_mv      (result.square_mv),
  .envelope_level (result.envelope_level),
  .env_stage      (result.env_stage)
);

`default_nettype wire

// ===== tb/aeo_env_osc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeo_env_osc_checker: envelope and oscillator predictor with result check
// Watches the tick, result and register channels, works out every expected
// result from its own copy of the block state and compares field by field.
// ----------------------------------------------------------------------------

module aeo_env_osc_checker (
  input  wire   clk,
  input  wire   rst,
  aeo_tick_if   tick,
  aeo_result_if result,
  aeo_cfg_if    cfg,
  output int    mismatches,
  output int    pending,
  output int    ticks_seen
);
  import aeo_pkg::*;

  typedef struct packed {
    logic signed [13:0] sine_mv;
    logic signed [13:0] triangle_mv;
    logic signed [13:0] saw_mv;
    logic signed [13:0] square_mv;
    logic [16:0]        envelope_level;
    logic [2:0]         env_stage;
  } wave_set_t;

  localparam longint unsigned FULL_Q31  = 64'd2147483648;
  localparam longint unsigned RAMP_BASE = (64'd1000 << 31) / SAMPLE_RATE;
  localparam longint unsigned OSC_BASE  = 64'd1123673395796 / SAMPLE_RATE;

  localparam int unsigned EXP_TAB [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
    44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
  };

  logic [16:0]     knob_regs [8];
  logic [15:0]     quarter_sine [SINE_DEPTH];
  logic [31:0]     phase_acc;
  logic [31:0]     env_q31;
  stage_t          env_stg;
  logic            gate_hi;
  wave_set_t       wave_queue [$];

  assign pending = wave_queue.size();

  function automatic longint unsigned exp2_neg(longint unsigned g);
    longint unsigned idx, r;
    idx = g >> 12;
    r   = g & 64'hFFF;
    if (idx >= 16) return 64'd32768;
    return EXP_TAB[idx] - (((EXP_TAB[idx] - EXP_TAB[idx + 1]) * r + 2048) >> 12);
  endfunction

  function automatic longint knob_sum(logic [16:0] knob, logic [16:0] amt,
                                      logic signed [14:0] cv);
    longint v;
    v = longint'(knob) + (longint'($signed(amt)) * longint'(cv)) / 5000;
    if (v < 0) v = 0;
    if (v > 65536) v = 65536;
    return v;
  endfunction

  function automatic longint unsigned ramp_step(longint v);
    longint unsigned e, n, f;
    e = (longint'(v) * 64'd870824) >> 16;
    n = e >> 16;
    f = e & 64'hFFFF;
    return (RAMP_BASE * exp2_neg(f)) >> (16 + n);
  endfunction

  function automatic logic [13:0] to_mv(longint w, longint unsigned lvl);
    longint unsigned mag, a;
    longint r;
    mag = (w < 0) ? -w : w;
    a   = (mag * lvl) >> 31;
    r   = longint'((a * 5000 + (64'd1 << 30)) >> 31);
    if (w < 0) r = -r;
    return r[13:0];
  endfunction

  function automatic longint unsigned sine_at(longint unsigned pos);
    longint unsigned k;
    k = (pos * SINE_DEPTH) >> 30;
    if (k >= SINE_DEPTH) return 64'd65535;
    return quarter_sine[k];
  endfunction

  task automatic load_defaults();
    longint unsigned x, x2, t, s, e, one;
    knob_regs = '{17'd6554, 17'd32768, 17'd32768, 17'd13107, 0, 0, 0, 0};
    phase_acc = '0;
    env_q31   = '0;
    env_stg   = STG_OFF;
    gate_hi   = 1'b0;
    one = 64'd1 << 30;
    // quarter sine by truncated odd power series
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x  = 64'd1686629713 * i / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t  = one;
      t  = one - ((x2 * t) >> 30) / 110;
      t  = one - ((x2 * t) >> 30) / 72;
      t  = one - ((x2 * t) >> 30) / 42;
      t  = one - ((x2 * t) >> 30) / 20;
      t  = one - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      e  = (s * 65535 + (64'd1 << 29)) >> 30;
      quarter_sine[i] = (e > 65535) ? 16'hFFFF : e[15:0];
    end
  endtask

  task automatic predict_tick();
    longint g, sv, rv, pitch, e2, w_sin, w_tri, w_saw, w_sqr;
    longint unsigned lvl, sus, inc, p32, m, val, ph, q, quad, s;
    logic fired;
    wave_set_t w;
    g = tick.gate_mv;
    fired = 1'b0;
    if (gate_hi) begin
      if (g <= 0) gate_hi = 1'b0;
    end else if (g >= 1000) begin
      gate_hi = 1'b1;
      fired = 1'b1;
    end
    if (fired) begin
      env_stg = STG_ATTACK;
    end else if (g < 1000 && (env_stg == STG_ATTACK || env_stg == STG_DECAY ||
                              env_stg == STG_SUSTAIN)) begin
      env_stg = STG_RELEASE;
    end
    sv  = knob_sum(knob_regs[CFG_SUSTAIN_KNOB], knob_regs[CFG_SUSTAIN_AMT],
                   tick.sustain_cv_mv);
    sus = longint'(sv) << 15;
    lvl = env_q31;
    case (env_stg)
      STG_ATTACK: begin
        lvl += ramp_step(knob_sum(knob_regs[CFG_ATTACK_KNOB], knob_regs[CFG_ATTACK_AMT],
                                  tick.attack_cv_mv));
        if (lvl >= FULL_Q31) begin
          lvl = FULL_Q31;
          env_stg = STG_DECAY;
        end
      end
      STG_DECAY: begin
        inc = ramp_step(knob_sum(knob_regs[CFG_DECAY_KNOB], knob_regs[CFG_DECAY_AMT],
                                 tick.decay_cv_mv));
        if (lvl <= sus + inc) begin
          lvl = sus;
          env_stg = STG_SUSTAIN;
        end else lvl -= inc;
      end
      STG_SUSTAIN: lvl = sus;
      STG_RELEASE: begin
        rv = longint'(knob_regs[CFG_RELEASE_KNOB]) +
             (longint'(RELEASE_CV_GAIN) * longint'(tick.release_cv_mv)) / 5000;
        if (rv < 0) rv = 0;
        if (rv > 65536) rv = 65536;
        inc = ramp_step(rv);
        if (lvl <= inc) begin
          lvl = 0;
          env_stg = STG_OFF;
        end else lvl -= inc;
      end
      default: begin
        lvl = 0;
        env_stg = STG_OFF;
      end
    endcase
    env_q31 = lvl[31:0];

    pitch = longint'($signed(knob_regs[CFG_PITCH_OFFSET][12:0])) +
            longint'(tick.pitch_mv) + 21000;
    p32 = (longint'(pitch) * 65536) / 1000;
    m   = exp2_neg(65536 - (p32 & 64'hFFFF));
    val = OSC_BASE * m;
    e2  = longint'(p32 >> 16) + 1 - 37;
    if (e2 >= 0) val = val << e2;
    else val = val >> (-e2);
    phase_acc = phase_acc + val[31:0];

    ph   = phase_acc;
    q    = ph & 64'h3FFFFFFF;
    quad = ph >> 30;
    s    = quad[0] ? sine_at((64'd1 << 30) - q) : sine_at(q);
    w_sin = longint'(s * 32768);
    if (quad >= 2) w_sin = -w_sin;
    w_saw = longint'(ph) - longint'(FULL_Q31);
    if (ph < FULL_Q31) begin
      w_sqr = FULL_Q31;
      w_tri = 2 * longint'(ph) - longint'(FULL_Q31);
    end else begin
      w_sqr = -longint'(FULL_Q31);
      w_tri = 3 * longint'(FULL_Q31) - 2 * longint'(ph);
    end

    w.sine_mv        = to_mv(w_sin, lvl);
    w.triangle_mv    = to_mv(w_tri, lvl);
    w.saw_mv         = to_mv(w_saw, lvl);
    w.square_mv      = to_mv(w_sqr, lvl);
    w.envelope_level = lvl[31:15];
    w.env_stage      = env_stg;
    wave_queue.push_back(w);
  endtask

  task automatic check_result();
    wave_set_t exp_w, act_w;
    act_w = '{result.sine_mv, result.triangle_mv, result.saw_mv, result.square_mv,
              result.envelope_level, result.env_stage};
    if (wave_queue.size() == 0) begin
      $display("%0t: result with nothing outstanding, actual %p", $time, act_w);
      mismatches++;
      return;
    end
    exp_w = wave_queue.pop_front();
    if (exp_w.sine_mv !== act_w.sine_mv || exp_w.triangle_mv !== act_w.triangle_mv ||
        exp_w.saw_mv !== act_w.saw_mv || exp_w.square_mv !== act_w.square_mv ||
        exp_w.envelope_level !== act_w.envelope_level ||
        exp_w.env_stage !== act_w.env_stage) begin
      $display("%0t: mismatch expected %p actual %p", $time, exp_w, act_w);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    ticks_seen = 0;
    load_defaults();
  end

  always @(posedge clk) begin
    if (rst) begin
      load_defaults();
      wave_queue.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        knob_regs[cfg.index] = (cfg.index == CFG_PITCH_OFFSET) ?
                               {4'd0, cfg.data[12:0]} : cfg.data;
      end
      if (result.valid && result.ready) check_result();
      if (tick.valid && tick.ready) begin
        predict_tick();
        ticks_seen++;
      end
    end
  end

endmodule

// ===== tb/tb_adsr_enveloped_oscillator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adsr_enveloped_oscillator: stimulus and verdict for the oscillator
// Drives sample ticks and register writes through several settings, with
// random gaps and stalls; the checker beside the block scores every result.
// ----------------------------------------------------------------------------

module tb_adsr_enveloped_oscillator;
  import aeo_pkg::*;

  logic clk;
  logic rst;
  int   mismatches, pending, ticks_seen;
  int   cfg_phases;
  bit   quiet;        // no idling on either side
  bit   long_hold;    // asks the receiver for one long stall

  aeo_tick_if   tick_ch ();
  aeo_result_if res_ch ();
  aeo_cfg_if    cfg_ch ();

  adsr_enveloped_oscillator u_top (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  aeo_env_osc_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick_ch),
    .result     (res_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending),
    .ticks_seen (ticks_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling, far beyond the slowest correct run
  initial begin
    #20ms;
    $display("adsr_enveloped_oscillator test failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // one tick request, with an optional random gap ahead of it
  task automatic send_tick(int g, int p, int a, int d, int s, int r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.gate_mv       <= 15'(g);
    tick_ch.pitch_mv      <= 15'(p);
    tick_ch.attack_cv_mv  <= 15'(a);
    tick_ch.decay_cv_mv   <= 15'(d);
    tick_ch.sustain_cv_mv <= 15'(s);
    tick_ch.release_cv_mv <= 15'(r);
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  // let every outstanding result drain, then the pipeline settle
  task automatic drain_results();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // writes all eight registers back to back while the block is idle
  task automatic write_regs(logic [16:0] v [8]);
    drain_results();
    for (int i = 0; i < 8; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= cfg_index_t'(i);
      cfg_ch.data  <= v[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    cfg_phases++;
  endtask

  function automatic int any_mv();
    return $signed(15'($urandom));
  endfunction

  function automatic int in_range_mv();
    return $urandom_range(0, 24000) - 12000;
  endfunction

  // notes: gate held high then low for random spans, random modulation
  task automatic play_notes(int count);
    int hold, g;
    bit up;
    up = 1'b1;
    hold = $urandom_range(5, 70);
    for (int n = 0; n < count; n++) begin
      if (hold == 0) begin
        up = !up;
        hold = up ? $urandom_range(5, 70) : $urandom_range(5, 90);
      end
      hold--;
      if ($urandom_range(0, 9) == 0) begin
        // noise: any gate voltage, including the dead zone of the trigger
        send_tick(any_mv(), any_mv(), any_mv(), any_mv(), any_mv(), any_mv());
      end else begin
        g = up ? $urandom_range(1000, 12000) : -$urandom_range(0, 12000);
        send_tick(g, in_range_mv(), in_range_mv(), in_range_mv(),
                  in_range_mv(), in_range_mv());
      end
    end
  endtask

  initial begin
    logic [16:0] regs [8];
    cfg_phases = 0;
    quiet = 1'b0;
    long_hold = 1'b0;
    rst <= 1'b1;
    tick_ch.valid <= 1'b0;
    tick_ch.gate_mv <= '0;
    tick_ch.pitch_mv <= '0;
    tick_ch.attack_cv_mv <= '0;
    tick_ch.decay_cv_mv <= '0;
    tick_ch.sustain_cv_mv <= '0;
    tick_ch.release_cv_mv <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_ATTACK_KNOB;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: trigger threshold, extremes, retrigger
    send_tick(999, 0, 0, 0, 0, 0);              // just below the threshold
    send_tick(1000, 12000, 12000, 12000, 12000, 12000);  // fires attack
    send_tick(12000, -12000, -12000, -12000, -12000, -12000);
    send_tick(500, 0, 0, 0, 0, 0);              // gate low, trigger still high
    send_tick(12000, 0, 0, 0, 0, 0);            // no refire while trigger high
    send_tick(0, 0, 0, 0, 0, 0);                // trigger drops
    send_tick(5000, 0, 0, 0, 0, 0);             // retrigger from current level
    send_tick(-12000, 0, 0, 0, 0, 0);
    send_tick(1, 0, 0, 0, 0, 0);
    send_tick(-16384, -16384, -16384, -16384, -16384, -16384);
    send_tick(16383, 16383, 16383, 16383, 16383, 16383);
    send_tick(-16384, 0, 0, 0, 0, 0);

    // fast ramps so attack, decay to sustain and release all complete
    regs = '{17'd0, 17'd0, 17'd32768, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0};
    write_regs(regs);
    for (int i = 0; i < 60; i++) send_tick(8000, 1000, 0, 0, 0, 0);
    // release, retrigger, then sustain CV driven high while its amount is zero
    send_tick(0, 0, 0, 0, 0, 0);
    send_tick(2000, 0, 0, 0, 0, 0);
    for (int i = 0; i < 52; i++) send_tick(2000, 0, 0, 0, 12000, 0);
    play_notes(100);

    // receiver holds off while ticks keep coming: the block stalls its input
    long_hold = 1'b1;
    play_notes(40);
    // sender waits for every outstanding result
    drain_results();
    play_notes(20);

    // extremes: slowest ramps, top pitch offset, full positive modulation
    regs = '{17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'(4000),
             17'd32768, 17'd32768, 17'd32768};
    write_regs(regs);
    play_notes(120);

    // bottom knobs, lowest pitch offset, full negative modulation
    regs = '{17'd0, 17'd0, 17'd0, 17'd0, 17'(-4000),
             17'(-32768), 17'(-32768), 17'(-32768)};
    write_regs(regs);
    play_notes(130);

    // random mid-range settings with short ramps
    for (int k = 0; k < 2; k++) begin
      regs[CFG_ATTACK_KNOB]  = 17'($urandom_range(0, 8000));
      regs[CFG_DECAY_KNOB]   = 17'($urandom_range(0, 8000));
      regs[CFG_SUSTAIN_KNOB] = 17'($urandom_range(0, 65536));
      regs[CFG_RELEASE_KNOB] = 17'($urandom_range(0, 8000));
      regs[CFG_PITCH_OFFSET] = 17'($urandom_range(0, 8000) - 4000);
      regs[CFG_ATTACK_AMT]   = 17'($urandom_range(0, 65536) - 32768);
      regs[CFG_DECAY_AMT]    = 17'($urandom_range(0, 65536) - 32768);
      regs[CFG_SUSTAIN_AMT]  = 17'($urandom_range(0, 65536) - 32768);
      write_regs(regs);
      play_notes(110);
    end

    // random register bit patterns, out-of-range sums clamp
    for (int i = 0; i < 8; i++) regs[i] = 17'($urandom);
    write_regs(regs);
    play_notes(100);

    // closing stretch at full rate, no idling either side
    regs = '{17'd0, 17'd3000, 17'd20000, 17'd2000, 17'd100,
             17'd16384, 17'(-16384), 17'd8000};
    write_regs(regs);
    quiet = 1'b1;
    play_notes(90);

    drain_results();
    repeat (60) @(posedge clk);
    $display("run covered %0d ticks over %0d register settings", ticks_seen, cfg_phases);
    $display("gate edges, all envelope stages, extreme pitch and clamped modulation");
    if (mismatches == 0) begin
      $display("adsr_enveloped_oscillator test passed");
    end else begin
      $display("adsr_enveloped_oscillator test failed");
    end
    $finish;
  end

endmodule
